/* rtl/earr_pkg.sv */
// ----------------------------------------------------------------------------
// Encoder angle readout package
// Shared types and constants for the angle readout with retry.
// ----------------------------------------------------------------------------
`default_nettype none

package earr_pkg;

  localparam int unsigned MAX_ATTEMPTS = 3;
  localparam logic [1:0] MAX_ATTEMPTS_C = 2'(MAX_ATTEMPTS);

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QUEUE_DEPTH);

  localparam logic [13:0] FULL_SCALE = 14'd16383;
  localparam logic [15:0] CENTI_TURN = 16'd36000;
  localparam logic [15:0] CENTI_HALF = 16'd18000;
  localparam logic [15:0] SCALE_MUL = 16'd36000;
  localparam logic [12:0] DIV100_MUL = 13'd5243;
  localparam int unsigned DIV100_SHIFT = 19;
  localparam logic [6:0] HUNDRED = 7'd100;
  localparam int unsigned FLAG_ERROR_POS = 14;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_WRITE   = 3'd1,
    ST_COMMAND = 3'd2,
    ST_READ    = 3'd3,
    ST_PARITY  = 3'd4
  } status_t;

  typedef struct packed {
    logic        write_ok;
    logic        read_ok;
    logic [15:0] response_word;
  } in_item_t;

  typedef struct packed {
    logic               done_res;
    status_t            status;
    logic        [15:0] raw_centidegrees;
    logic signed [15:0] signed_angle;
  } out_item_t;

  typedef struct packed {
    logic        done_res;
    status_t     status;
    logic [13:0] angle;
  } job_t;

endpackage

`default_nettype wire

/* rtl/earr_front.sv */
// ----------------------------------------------------------------------------
// Front end
// Accepts read attempts, classifies them and tracks the retry count.
// ----------------------------------------------------------------------------
`default_nettype none

module earr_front (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire earr_pkg::in_item_t in_item,
  input  wire logic              queue_full,
  output logic                   push,
  output earr_pkg::job_t         job
);
  import earr_pkg::*;

  logic [1:0] attempt_count;
  logic [1:0] attempt_count_next;
  logic [1:0] attempt_inc;
  status_t    status;

  assign in_stall = queue_full;
  assign push = in_valid && !queue_full;

  always_comb begin
    if (!in_item.write_ok) begin
      status = ST_WRITE;
    end else if (!in_item.read_ok) begin
      status = ST_READ;
    end else if (in_item.response_word[FLAG_ERROR_POS]) begin
      status = ST_COMMAND;
    end else if (^in_item.response_word) begin
      status = ST_PARITY;
    end else begin
      status = ST_OK;
    end
  end

  always_comb begin
    attempt_inc = attempt_count + 2'd1;
    job.status = status;
    job.angle = in_item.response_word[13:0];
    if (status == ST_OK) begin
      job.done_res = 1'b1;
      attempt_count_next = '0;
    end else if (attempt_inc >= MAX_ATTEMPTS_C) begin
      job.done_res = 1'b1;
      attempt_count_next = '0;
    end else begin
      job.done_res = 1'b0;
      attempt_count_next = attempt_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      attempt_count <= '0;
    end else if (push) begin
      attempt_count <= attempt_count_next;
    end
  end

endmodule

`default_nettype wire

/* rtl/earr_queue.sv */
// ----------------------------------------------------------------------------
// Job queue
// Short first-in first-out buffer between the front and back ends.
// ----------------------------------------------------------------------------
`default_nettype none

module earr_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire earr_pkg::job_t push_job,
  output logic                full,
  input  wire logic           pop,
  output logic                not_empty,
  output earr_pkg::job_t      head
);
  import earr_pkg::*;

  job_t              entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;

  assign full = (count == (QPTR_W+1)'(QUEUE_DEPTH));
  assign not_empty = (count != '0);
  assign head = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10: count <= count + 1'b1;
        2'b01: count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

/* rtl/earr_back.sv */
// ----------------------------------------------------------------------------
// Back end
// Five stage pipeline that scales the angle, folds it and holds the result.
// ----------------------------------------------------------------------------
`default_nettype none

module earr_back (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic [15:0]     initial_centidegrees,
  input  wire logic            job_valid,
  input  wire earr_pkg::job_t  job,
  output logic                 pop,
  output logic                 out_valid,
  input  wire logic            out_stall,
  output earr_pkg::out_item_t  out_item
);
  import earr_pkg::*;

  logic v1, v2, v3, v4;
  logic en1, en2, en3, en4, en5;

  logic        s1_done, s2_done, s3_done, s4_done;
  status_t     s1_status, s2_status, s3_status, s4_status;
  logic [29:0] s1_prod;
  logic [15:0] s2_raw, s3_raw, s4_raw;
  logic [14:0] s3_mag;
  logic        s3_neg, s4_neg;
  logic [27:0] s4_prod;

  logic [15:0] quot;
  logic [15:0] rem;
  logic [15:0] raw_next;
  logic [16:0] diff;
  logic [16:0] diff_wrap;
  logic [15:0] d;
  logic        neg_next;
  logic [14:0] mag_next;
  logic [7:0]  hundreds;
  logic [14:0] trunc;
  logic        ok;

  assign en5 = !out_valid || !out_stall;
  assign en4 = !v4 || en5;
  assign en3 = !v3 || en4;
  assign en2 = !v2 || en3;
  assign en1 = !v1 || en2;
  assign pop = job_valid && en1;

  // Division by 16383 = 2^14 - 1: the remainder estimate stays below 4 * 16383.
  always_comb begin
    quot = 16'(s1_prod >> 14);
    rem = 16'(s1_prod[13:0]) + quot;
    raw_next = quot;
    if (rem >= 16'(3 * FULL_SCALE)) begin
      raw_next = quot + 16'd3;
    end else if (rem >= 16'(2 * FULL_SCALE)) begin
      raw_next = quot + 16'd2;
    end else if (rem >= 16'(FULL_SCALE)) begin
      raw_next = quot + 16'd1;
    end
  end

  always_comb begin
    diff = {1'b0, initial_centidegrees} - {1'b0, s2_raw};
    if (diff[16]) begin
      diff_wrap = diff + {1'b0, CENTI_TURN};
    end else if (diff > {1'b0, CENTI_TURN}) begin
      diff_wrap = diff - {1'b0, CENTI_TURN};
    end else begin
      diff_wrap = diff;
    end
    d = diff_wrap[15:0];
    neg_next = (d <= CENTI_HALF);
    if (neg_next) begin
      mag_next = d[14:0];
    end else begin
      mag_next = 15'(CENTI_TURN - d);
    end
  end

  always_comb begin
    hundreds = s4_prod[DIV100_SHIFT +: 8];
    trunc = 15'(hundreds * HUNDRED);
    ok = (s4_status == ST_OK);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (en1) begin
        v1 <= job_valid;
      end
      if (en2) begin
        v2 <= v1;
      end
      if (en3) begin
        v3 <= v2;
      end
      if (en4) begin
        v4 <= v3;
      end
      if (en5) begin
        out_valid <= v4;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      s1_done <= job.done_res;
      s1_status <= job.status;
      s1_prod <= 30'(job.angle * SCALE_MUL);
    end
    if (en2) begin
      s2_done <= s1_done;
      s2_status <= s1_status;
      s2_raw <= raw_next;
    end
    if (en3) begin
      s3_done <= s2_done;
      s3_status <= s2_status;
      s3_raw <= s2_raw;
      s3_mag <= mag_next;
      s3_neg <= neg_next;
    end
    if (en4) begin
      s4_done <= s3_done;
      s4_status <= s3_status;
      s4_raw <= s3_raw;
      s4_neg <= s3_neg;
      s4_prod <= 28'(s3_mag * DIV100_MUL);
    end
    if (en5) begin
      out_item.done_res <= s4_done;
      out_item.status <= s4_status;
      if (!ok) begin
        out_item.raw_centidegrees <= '0;
        out_item.signed_angle <= '0;
      end else if (s4_neg) begin
        out_item.raw_centidegrees <= s4_raw;
        out_item.signed_angle <= -$signed({1'b0, trunc});
      end else begin
        out_item.raw_centidegrees <= s4_raw;
        out_item.signed_angle <= $signed({1'b0, trunc});
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/encoder_angle_readout_with_retry.sv */
// ----------------------------------------------------------------------------
// Encoder angle readout with retry
// Checks each read attempt, flags failed reads for retry and reports folded angles.
// ----------------------------------------------------------------------------
//  channel  direction  handshake            payload
//  in       input      in_valid/in_stall    in_item (in_item_t)
//  out      output     out_valid/out_stall  out_item (out_item_t)
//  cfg      input      cfg_wr_en            cfg_wr_data (initial_centidegrees)
//
// One attempt is accepted per cycle while the four entry queue has room.
// An accepted job passes the queue, then back stages s1 to s4 and the output register.
// Reset clears the retry count, the queue and all stage valids.
// The output stall backs up the pipeline, then the queue, then the input.
// ----------------------------------------------------------------------------
`default_nettype none

module encoder_angle_readout_with_retry (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                cfg_wr_en,
  input  wire logic [15:0]         cfg_wr_data,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire earr_pkg::in_item_t  in_item,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output earr_pkg::out_item_t      out_item
);
  import earr_pkg::*;

  logic [15:0] initial_centidegrees;
  logic        push;
  job_t        push_job;
  logic        queue_full;
  logic        pop;
  logic        job_valid;
  job_t        head;

  always_ff @(posedge clk) begin
    if (rst) begin
      initial_centidegrees <= '0;
    end else if (cfg_wr_en) begin
      initial_centidegrees <= cfg_wr_data;
    end
  end

  earr_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_item    (in_item),
    .queue_full (queue_full),
    .push       (push),
    .job        (push_job)
  );

  earr_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_job  (push_job),
    .full      (queue_full),
    .pop       (pop),
    .not_empty (job_valid),
    .head      (head)
  );

  earr_back u_back (
    .clk                  (clk),
    .rst                  (rst),
    .initial_centidegrees (initial_centidegrees),
    .job_valid            (job_valid),
    .job                  (head),
    .pop                  (pop),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_item             (out_item)
  );

  a_retry_not_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_item.done_res |-> out_item.status != ST_OK)
    else $error("retry request carries an ok status");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.status != ST_OK |->
      out_item.raw_centidegrees == '0 && out_item.signed_angle == '0)
    else $error("failed attempt carries angle data");

  a_raw_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.status == ST_OK |-> out_item.raw_centidegrees <= CENTI_TURN)
    else $error("scaled angle out of range");

  a_fold_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_item.signed_angle <= 16'sd18000 && out_item.signed_angle >= -16'sd18000)
    else $error("folded angle out of range");

endmodule

`default_nettype wire

/* dv/earr_readout_checker.sv */
// ----------------------------------------------------------------------------
// Encoder angle readout checker
// Watches the configuration, input and output channels of the angle readout.
// Each accepted attempt word is turned into an expected readout by a local
// model of the retry count and the angle arithmetic. Each accepted output word
// is compared field by field with the oldest expected readout.
// ----------------------------------------------------------------------------
module earr_readout_checker (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_wr_en,
  input  logic [15:0]         cfg_wr_data,
  input  logic                in_valid,
  input  logic                in_stall,
  input  earr_pkg::in_item_t  in_item,
  input  logic                out_valid,
  input  logic                out_stall,
  input  earr_pkg::out_item_t out_item,
  output int                  readouts_pending,
  output int                  mismatch_count
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TURN = 36000;
  localparam int HALF = 18000;
  localparam int FULL = 16383;

  earr_pkg::out_item_t expected_readouts[$];
  logic [15:0]         reference_cd = '0;
  logic [1:0]          failed_attempts = '0;
  int                  errors = 0;

  initial begin
    readouts_pending = 0;
    mismatch_count = 0;
  end

  function automatic earr_pkg::out_item_t predict_readout(earr_pkg::in_item_t w,
                                                          logic [15:0] ref_cd,
                                                          logic [1:0] fails);
    earr_pkg::out_item_t r;
    int raw;
    int d;
    int folded;
    r = '0;
    if (!w.write_ok) begin
      r.status = earr_pkg::ST_WRITE;
    end else if (!w.read_ok) begin
      r.status = earr_pkg::ST_READ;
    end else if (w.response_word[14]) begin
      r.status = earr_pkg::ST_COMMAND;
    end else if (^w.response_word) begin
      r.status = earr_pkg::ST_PARITY;
    end else begin
      r.status = earr_pkg::ST_OK;
    end
    if (r.status == earr_pkg::ST_OK) begin
      raw = (int'(w.response_word[13:0]) * TURN) / FULL;
      d = int'(ref_cd) - raw;
      if (d < 0) d += TURN;
      if (d > TURN) d -= TURN;
      if (d <= HALF) begin
        folded = -((d / 100) * 100);
      end else begin
        folded = ((TURN - d) / 100) * 100;
      end
      r.done_res = 1'b1;
      r.raw_centidegrees = 16'(raw);
      r.signed_angle = 16'(folded);
    end else begin
      r.done_res = (int'(fails) + 1 >= int'(earr_pkg::MAX_ATTEMPTS));
    end
    return r;
  endfunction

  always @(posedge clk) begin : watch
    earr_pkg::out_item_t want;
    if (rst) begin
      expected_readouts.delete();
      reference_cd = '0;
      failed_attempts = '0;
    end else begin
      if (cfg_wr_en) reference_cd = cfg_wr_data;
      if (out_valid && !out_stall) begin
        if (expected_readouts.size() == 0) begin
          $error("output word with no expected readout waiting: status %0d angle %0d",
                 out_item.status, $signed(out_item.signed_angle));
          errors++;
        end else begin
          want = expected_readouts.pop_front();
          if (out_item.done_res !== want.done_res) begin
            $error("done_res: expected %0d, actual %0d", want.done_res, out_item.done_res);
            errors++;
          end
          if (out_item.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, out_item.status);
            errors++;
          end
          if (out_item.raw_centidegrees !== want.raw_centidegrees) begin
            $error("raw_centidegrees: expected %0d, actual %0d",
                   want.raw_centidegrees, out_item.raw_centidegrees);
            errors++;
          end
          if (out_item.signed_angle !== want.signed_angle) begin
            $error("signed_angle: expected %0d, actual %0d",
                   $signed(want.signed_angle), $signed(out_item.signed_angle));
            errors++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        want = predict_readout(in_item, reference_cd, failed_attempts);
        expected_readouts.push_back(want);
        failed_attempts = want.done_res ? 2'd0 : failed_attempts + 2'd1;
      end
    end
    readouts_pending <= expected_readouts.size();
    mismatch_count <= errors;
  end

endmodule

/* dv/tb_encoder_angle_readout_with_retry.sv */
// ----------------------------------------------------------------------------
// Encoder angle readout testbench
// Drives read attempts into the angle readout: a directed set covering the
// failure codes, the retry limit and the angle boundaries, then random
// phases over several reference angles and idling patterns, including a long
// output hold that backs the block up. A checker predicts and compares.
// ----------------------------------------------------------------------------
module tb_encoder_angle_readout_with_retry;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int LONG_HOLD = 300;
  localparam int PHASE_WORDS = 156;
  localparam int DRAIN_CYCLES = 20;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  logic                clk;
  logic                rst = 1'b1;
  logic                cfg_wr_en = 1'b0;
  logic [15:0]         cfg_wr_data = '0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  earr_pkg::in_item_t  in_item = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  earr_pkg::out_item_t out_item;

  int readouts_pending;
  int mismatch_count;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_ticket = 0;
  int holds_served = 0;
  int hold_cycles = 0;

  encoder_angle_readout_with_retry i_dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_item    (in_item),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_item   (out_item)
  );

  earr_readout_checker i_checker (
    .clk             (clk),
    .rst             (rst),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_item         (in_item),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_item        (out_item),
    .readouts_pending(readouts_pending),
    .mismatch_count  (mismatch_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    forever begin
      @(posedge clk);
      if (hold_ticket != holds_served) begin
        holds_served = hold_ticket;
        hold_cycles = LONG_HOLD;
      end
      if (hold_cycles > 0) begin
        out_stall <= 1'b1;
        hold_cycles--;
      end else begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic logic [15:0] encode_response(logic [13:0] angle, logic err_flag,
                                                  logic bad_parity);
    return {^{err_flag, angle} ^ bad_parity, err_flag, angle};
  endfunction

  function automatic earr_pkg::in_item_t attempt(logic wok, logic rok, logic [15:0] word);
    earr_pkg::in_item_t w;
    w.write_ok = wok;
    w.read_ok = rok;
    w.response_word = word;
    return w;
  endfunction

  function automatic earr_pkg::in_item_t random_attempt();
    int pick;
    logic [13:0] angle;
    logic [15:0] word;
    pick = $urandom_range(99);
    if (pick < 5) begin
      angle = '0;
    end else if (pick < 10) begin
      angle = 14'h3FFF;
    end else begin
      angle = 14'($urandom);
    end
    if ($urandom_range(19) == 0) begin
      word = 16'($urandom);
    end else begin
      word = encode_response(angle, $urandom_range(9) == 0, $urandom_range(9) == 0);
    end
    return attempt($urandom_range(9) != 0, $urandom_range(9) != 0, word);
  endfunction

  task automatic send_word(earr_pkg::in_item_t w);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_item <= w;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic drain_readouts();
    in_valid <= 1'b0;
    @(posedge clk);
    while (readouts_pending != 0) @(posedge clk);
  endtask

  task automatic write_reference(logic [15:0] cd);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= cd;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic set_idling(idle_mode_t mode);
    case (mode)
      IDLE_NONE: begin
        send_idle_pct = 0;
        recv_stall_pct <= 0;
      end
      IDLE_SENDER: begin
        send_idle_pct = 58;
        recv_stall_pct <= 0;
      end
      IDLE_RECEIVER: begin
        send_idle_pct = 0;
        recv_stall_pct <= 58;
      end
      default: begin
        send_idle_pct = 8;
        recv_stall_pct <= 8;
      end
    endcase
  endtask

  initial begin : stimulus
    logic [15:0] phase_ref [8];
    phase_ref = '{16'd0, 16'd36000, 16'd18000, 16'hFFFF, 16'd1, 16'd35999,
                  16'($urandom_range(36000)), 16'($urandom)};
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    write_reference(16'd18000);
    send_word(attempt(1'b1, 1'b1, encode_response(14'd0, 1'b0, 1'b0)));
    send_word(attempt(1'b1, 1'b1, encode_response(14'h3FFF, 1'b0, 1'b0)));
    send_word(attempt(1'b1, 1'b1, encode_response(14'd8192, 1'b0, 1'b0)));
    send_word(attempt(1'b0, 1'b1, encode_response(14'd77, 1'b0, 1'b0)));
    send_word(attempt(1'b1, 1'b0, encode_response(14'd77, 1'b0, 1'b0)));
    send_word(attempt(1'b0, 1'b0, 16'hFFFF));
    send_word(attempt(1'b1, 1'b1, encode_response(14'd0, 1'b1, 1'b0)));
    send_word(attempt(1'b1, 1'b1, encode_response(14'd5, 1'b0, 1'b1)));
    send_word(attempt(1'b1, 1'b1, encode_response(14'd100, 1'b0, 1'b0)));
    send_word(attempt(1'b1, 1'b1, 16'hFFFF));
    send_word(attempt(1'b1, 1'b1, 16'h8000));
    send_word(attempt(1'b0, 1'b1, 16'hFFFF));
    send_word(attempt(1'b1, 1'b1, encode_response(14'h3FFF, 1'b1, 1'b1)));
    send_word(attempt(1'b1, 1'b1, encode_response(14'd4096, 1'b0, 1'b0)));
    send_word(attempt(1'b1, 1'b0, 16'h0000));
    send_word(attempt(1'b1, 1'b1, encode_response(14'd12288, 1'b0, 1'b0)));
    drain_readouts();
    write_reference(16'd36000);
    send_word(attempt(1'b1, 1'b1, 16'h0000));
    send_word(attempt(1'b1, 1'b1, encode_response(14'h3FFF, 1'b0, 1'b0)));
    drain_readouts();
    write_reference(16'hFFFF);
    send_word(attempt(1'b1, 1'b1, 16'h0000));
    send_word(attempt(1'b1, 1'b1, encode_response(14'h3FFF, 1'b0, 1'b0)));

    for (int ph = 0; ph < 8; ph++) begin
      drain_readouts();
      write_reference(phase_ref[ph]);
      set_idling(idle_mode_t'(ph % 4));
      if (ph == 4) hold_ticket <= hold_ticket + 1;
      repeat (PHASE_WORDS) send_word(random_attempt());
    end

    drain_readouts();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
